// ----- design/bdc_pkg.sv -----
// Shared types, widths and helper functions for the cubic Bezier splat pipeline.
// Used by every module in the design folder; depends on nothing.
package bdc_pkg;

	localparam int COORD_W         = 10;
	localparam int SUB_W           = 8;
	localparam int POS_W           = COORD_W + SUB_W;
	localparam int PARAM_IN_W      = 17;
	localparam int WGT_W           = 8;
	localparam int NUM_PIX         = 4;
	localparam int NUM_REGS        = 8;
	localparam int REG_IDX_W       = 3;
	localparam int SUM_W           = 18;
	localparam int ROOT_W          = 7;
	localparam int DEF_FRAME_W     = 1024;
	localparam int DEF_FRAME_H     = 1024;
	localparam int DEF_FRAC_BITS   = 16;

	localparam logic [REG_IDX_W-1:0] REG_P0_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_P0_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_P1_X = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_P1_Y = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_P2_X = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_P2_Y = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_P3_X = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_P3_Y = 3'd7;

	localparam logic [WGT_W-1:0] WGT_FULL = 8'd128;
	localparam logic [WGT_W-1:0] WGT_TOP  = 8'd127;

	typedef struct packed {
		logic [COORD_W-1:0]              px;
		logic [COORD_W-1:0]              py;
		logic [NUM_PIX-1:0]              mask;
		logic [NUM_PIX-1:0][WGT_W-1:0]   wgt;
	} splat_t;

	// One step of the greedy root search: keep the trial bit while 2*m*m stays below s.
	function automatic logic [ROOT_W-1:0] root_step(input logic [SUM_W-1:0] s,
			input logic [ROOT_W-1:0] m, input logic [ROOT_W-1:0] trial);
		logic [ROOT_W-1:0] cand;
		logic [SUM_W-1:0]  sq;
		cand = m | trial;
		sq   = SUM_W'({cand, 1'b0}) * SUM_W'(cand);
		return (sq < s) ? cand : m;
	endfunction

endpackage

// ----- design/bezier_de_casteljau_antialias_splat.sv -----
// Cubic Bezier point splatter: de Casteljau in three stages, weights in three, then a serialiser.
// Throughput: one parameter per cycle into the pipeline while in_stall is low; the serialiser
// sends one pixel a cycle while out_stall is low, one request per in-frame pixel of an item.
// Reset: arst_n clears the valid bits and the control point registers to zero.
module bezier_de_casteljau_antialias_splat #(
	parameter int FRAME_WIDTH     = bdc_pkg::DEF_FRAME_W,
	parameter int FRAME_HEIGHT    = bdc_pkg::DEF_FRAME_H,
	parameter int PARAM_FRAC_BITS = bdc_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bdc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bdc_pkg::COORD_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bdc_pkg::PARAM_IN_W-1:0] curve_param,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bdc_pkg::COORD_W-1:0]   pixel_x,
	output logic [bdc_pkg::COORD_W-1:0]   pixel_y,
	output logic [bdc_pkg::WGT_W-1:0]     green_add,
	output logic                          last_splat
);
	import bdc_pkg::*;

	localparam int TW = PARAM_FRAC_BITS + 1;
	localparam int CW = (TW > PARAM_IN_W) ? TW : PARAM_IN_W;
	localparam logic [CW-1:0] ONE = CW'(1) << PARAM_FRAC_BITS;

	logic [NUM_REGS-1:0][COORD_W-1:0] regs_q;
	logic [3:0][COORD_W-1:0]          cx, cy;
	logic [CW-1:0]                    t_ext;
	logic [TW-1:0]                    t_sat;
	logic                             adv, load, v_s3, v_s6;
	logic [POS_W-1:0]                 x_s3, y_s3;
	splat_t                           item_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_wdata;
		end
	end

	assign cx = {regs_q[REG_P3_X], regs_q[REG_P2_X], regs_q[REG_P1_X], regs_q[REG_P0_X]};
	assign cy = {regs_q[REG_P3_Y], regs_q[REG_P2_Y], regs_q[REG_P1_Y], regs_q[REG_P0_Y]};

	// Parameters beyond one are clamped to exactly one.
	assign t_ext = CW'(curve_param);
	assign t_sat = (t_ext > ONE) ? TW'(ONE) : TW'(t_ext);

	// The whole pipeline moves together whenever its last stage is empty or can empty into the serialiser.
	assign adv      = !v_s6 || load;
	assign in_stall = !adv;

	bdc_curve #(.TW(TW)) u_curve (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_v(in_valid), .t_in(t_sat),
		.cx(cx), .cy(cy), .v_s3(v_s3), .x_s3(x_s3), .y_s3(y_s3)
	);

	bdc_splat #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_splat (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(v_s3), .x_in(x_s3), .y_in(y_s3),
		.v_s6(v_s6), .item_s6(item_s6)
	);

	bdc_serial u_serial (
		.clk(clk), .arst_n(arst_n), .v_in(v_s6), .item_in(item_s6), .load(load),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.green_add(green_add), .last_splat(last_splat)
	);

endmodule

// ----- design/bdc_lerp.sv -----
// One rounding linear interpolation between two Q10.8 positions.
// Depends on bdc_pkg for the position width.
module bdc_lerp #(
	parameter int TW = bdc_pkg::DEF_FRAC_BITS + 1
) (
	input  logic [bdc_pkg::POS_W-1:0] a,
	input  logic [bdc_pkg::POS_W-1:0] b,
	input  logic [TW-1:0]             t,
	output logic [bdc_pkg::POS_W-1:0] y
);
	import bdc_pkg::*;

	localparam int P  = TW - 1;
	localparam int PW = POS_W + 1 + TW + 1;
	localparam logic signed [PW-1:0] HALF = PW'(1) << (P - 1);

	logic signed [POS_W:0]  diff;
	logic signed [PW-1:0]   prod;
	logic signed [PW-1:0]   shifted;

	// a*(1-t) + b*t equals a*ONE + (b-a)*t, so the a term passes the shift untouched.
	assign diff    = $signed({1'b0, b}) - $signed({1'b0, a});
	assign prod    = PW'(diff) * $signed({1'b0, t});
	assign shifted = (prod + HALF) >>> P;
	assign y       = a + shifted[POS_W-1:0];

endmodule

// ----- design/bdc_curve.sv -----
// Three register stages of de Casteljau interpolation on both coordinates.
// Depends on bdc_pkg and bdc_lerp.
module bdc_curve #(
	parameter int TW = bdc_pkg::DEF_FRAC_BITS + 1
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     adv,
	input  logic                                     in_v,
	input  logic [TW-1:0]                            t_in,
	input  logic [3:0][bdc_pkg::COORD_W-1:0]         cx,
	input  logic [3:0][bdc_pkg::COORD_W-1:0]         cy,
	output logic                                     v_s3,
	output logic [bdc_pkg::POS_W-1:0]                x_s3,
	output logic [bdc_pkg::POS_W-1:0]                y_s3
);
	import bdc_pkg::*;

	logic [3:0][POS_W-1:0] px0, py0;
	logic [2:0][POS_W-1:0] l1x, l1y, x_s1, y_s1;
	logic [1:0][POS_W-1:0] l2x, l2y, x_s2, y_s2;
	logic [POS_W-1:0]      l3x, l3y;
	logic [TW-1:0]         t_s1, t_s2;
	logic                  v_s1, v_s2;

	for (genvar k = 0; k < 4; k++) begin : g_in
		assign px0[k] = {cx[k], SUB_W'(0)};
		assign py0[k] = {cy[k], SUB_W'(0)};
	end

	for (genvar k = 0; k < 3; k++) begin : g_l1
		bdc_lerp #(.TW(TW)) u_lx (.a(px0[k]), .b(px0[k+1]), .t(t_in), .y(l1x[k]));
		bdc_lerp #(.TW(TW)) u_ly (.a(py0[k]), .b(py0[k+1]), .t(t_in), .y(l1y[k]));
	end

	for (genvar k = 0; k < 2; k++) begin : g_l2
		bdc_lerp #(.TW(TW)) u_lx (.a(x_s1[k]), .b(x_s1[k+1]), .t(t_s1), .y(l2x[k]));
		bdc_lerp #(.TW(TW)) u_ly (.a(y_s1[k]), .b(y_s1[k+1]), .t(t_s1), .y(l2y[k]));
	end

	bdc_lerp #(.TW(TW)) u_l3x (.a(x_s2[0]), .b(x_s2[1]), .t(t_s2), .y(l3x));
	bdc_lerp #(.TW(TW)) u_l3y (.a(y_s2[0]), .b(y_s2[1]), .t(t_s2), .y(l3y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= l1x;
			y_s1 <= l1y;
			t_s1 <= t_in;
			x_s2 <= l2x;
			y_s2 <= l2y;
			t_s2 <= t_s1;
			x_s3 <= l3x;
			y_s3 <= l3y;
		end
	end

endmodule

// ----- design/bdc_splat.sv -----
// Splat weights for the 2x2 pixel block: squared distances, then a two-stage root search.
// Depends on bdc_pkg.
module bdc_splat #(
	parameter int FRAME_WIDTH  = bdc_pkg::DEF_FRAME_W,
	parameter int FRAME_HEIGHT = bdc_pkg::DEF_FRAME_H
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      v_in,
	input  logic [bdc_pkg::POS_W-1:0] x_in,
	input  logic [bdc_pkg::POS_W-1:0] y_in,
	output logic                      v_s6,
	output bdc_pkg::splat_t           item_s6
);
	import bdc_pkg::*;

	logic [COORD_W-1:0]             px, py, px_s4, py_s4, px_s5, py_s5;
	logic [SUB_W-1:0]               fx, fy;
	logic [1:0][SUB_W:0]            ex, ey;
	logic [NUM_PIX-1:0][SUM_W-1:0]  sum, sum_s4, sum_s5;
	logic [NUM_PIX-1:0]             mask, mask_s4, mask_s5;
	logic [NUM_PIX-1:0][ROOT_W-1:0] hi_root, root_s5, lo_root;
	splat_t                         item;
	logic                           v_s4, v_s5;

	assign px = x_in[POS_W-1:SUB_W];
	assign py = y_in[POS_W-1:SUB_W];
	assign fx = x_in[SUB_W-1:0];
	assign fy = y_in[SUB_W-1:0];
	assign ex[0] = {1'b0, fx};
	assign ex[1] = (SUB_W+1)'(1 << SUB_W) - {1'b0, fx};
	assign ey[0] = {1'b0, fy};
	assign ey[1] = (SUB_W+1)'(1 << SUB_W) - {1'b0, fy};

	// Pixel order is (i,j) -> 2*i+j, i stepping the column.
	for (genvar n = 0; n < NUM_PIX; n++) begin : g_pix
		assign sum[n] = SUM_W'(ex[n/2]) * SUM_W'(ex[n/2]) + SUM_W'(ey[n%2]) * SUM_W'(ey[n%2]);
		assign mask[n] = (({1'b0, px} + (COORD_W+1)'(n/2)) < (COORD_W+1)'(FRAME_WIDTH)) &&
				(({1'b0, py} + (COORD_W+1)'(n%2)) < (COORD_W+1)'(FRAME_HEIGHT));

		always_comb begin
			hi_root[n] = root_step(sum_s4[n], '0, 7'h40);
			hi_root[n] = root_step(sum_s4[n], hi_root[n], 7'h20);
			hi_root[n] = root_step(sum_s4[n], hi_root[n], 7'h10);
		end

		always_comb begin
			lo_root[n] = root_step(sum_s5[n], root_s5[n], 7'h08);
			lo_root[n] = root_step(sum_s5[n], lo_root[n], 7'h04);
			lo_root[n] = root_step(sum_s5[n], lo_root[n], 7'h02);
			lo_root[n] = root_step(sum_s5[n], lo_root[n], 7'h01);
		end

		// The least k with 2k*k >= s is one above the largest root found; zero sum is full weight.
		assign item.wgt[n] = (sum_s5[n] == '0) ? WGT_FULL : WGT_TOP - WGT_W'(lo_root[n]);
	end

	assign item.px   = px_s5;
	assign item.py   = py_s5;
	assign item.mask = mask_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_in;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s4   <= px;
			py_s4   <= py;
			sum_s4  <= sum;
			mask_s4 <= mask;
			px_s5   <= px_s4;
			py_s5   <= py_s4;
			sum_s5  <= sum_s4;
			mask_s5 <= mask_s4;
			root_s5 <= hi_root;
			item_s6 <= item;
		end
	end

endmodule

// ----- design/bdc_serial.sv -----
// Output stage: holds one splat and hands out its in-frame pixels one request at a time.
// Depends on bdc_pkg.
module bdc_serial (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        v_in,
	input  bdc_pkg::splat_t             item_in,
	output logic                        load,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bdc_pkg::COORD_W-1:0] pixel_x,
	output logic [bdc_pkg::COORD_W-1:0] pixel_y,
	output logic [bdc_pkg::WGT_W-1:0]   green_add,
	output logic                        last_splat
);
	import bdc_pkg::*;

	logic [NUM_PIX-1:0] mask_q, pick;
	splat_t             item_q;
	logic [1:0]         idx;
	logic               single;

	assign pick   = mask_q & (~mask_q + NUM_PIX'(1));
	assign single = (mask_q & (mask_q - NUM_PIX'(1))) == '0;

	always_comb begin
		case (pick)
			4'b0010: idx = 2'd1;
			4'b0100: idx = 2'd2;
			4'b1000: idx = 2'd3;
			default: idx = 2'd0;
		endcase
	end

	assign out_valid  = mask_q != '0;
	assign last_splat = single;
	assign pixel_x    = item_q.px + COORD_W'(idx[1]);
	assign pixel_y    = item_q.py + COORD_W'(idx[0]);
	assign green_add  = item_q.wgt[idx];
	assign load       = !out_valid || (single && !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= v_in ? item_in.mask : '0;
		end else if (!out_stall) begin
			mask_q <= mask_q & ~pick;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item_in;
		end
	end

endmodule

// ----- design/bdc_checker.sv -----
// Port-level checks for the Bezier splatter, bound onto the top level.
// Depends on bdc_pkg and on the top level's port list.
module bdc_checker #(
	parameter int FRAME_WIDTH  = bdc_pkg::DEF_FRAME_W,
	parameter int FRAME_HEIGHT = bdc_pkg::DEF_FRAME_H
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [bdc_pkg::COORD_W-1:0] pixel_x,
	input logic [bdc_pkg::COORD_W-1:0] pixel_y,
	input logic [bdc_pkg::WGT_W-1:0]   green_add,
	input logic                        last_splat
);
	import bdc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y) &&
		$stable(green_add) && $stable(last_splat))
		else $error("stalled request changed");

	a_weight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> green_add <= WGT_FULL)
		else $error("green increment above full weight");

	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(pixel_x) < FRAME_WIDTH) && (32'(pixel_y) < FRAME_HEIGHT))
		else $error("pixel outside the frame");

	a_rest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_splat |=> out_valid)
		else $error("splat ended before its last pixel");

endmodule

bind bezier_de_casteljau_antialias_splat bdc_checker #(
	.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)
) u_bdc_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.pixel_x(pixel_x), .pixel_y(pixel_y), .green_add(green_add), .last_splat(last_splat)
);
